### hdl/pit_pkg.sv
// Shared constants for the point-in-triangle edge-function test.
// No dependencies; used by pit_in_if, point_in_triangle_test and the testbench.

package pit_pkg;

	localparam int COORD_BITS_DEF = 32;

	localparam int DIM_W      = 2;
	localparam int TOL_W      = 31;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 31;

	localparam logic [CFG_IDX_W-1:0] REG_SPACE_DIM = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'b1;

	localparam logic [DIM_W-1:0] DIM_2D = 2'd2;
	localparam logic [DIM_W-1:0] DIM_3D = 2'd3;

endpackage

### hdl/pit_in_if.sv
// Query channel: triangle vertices and query point, valid/ready handshake.
// Depends on pit_pkg for the default coordinate width.

interface pit_in_if #(
	parameter int COORD_BITS = pit_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] ax;
	logic signed [COORD_BITS-1:0] ay;
	logic signed [COORD_BITS-1:0] az;
	logic signed [COORD_BITS-1:0] bx;
	logic signed [COORD_BITS-1:0] by_coord;
	logic signed [COORD_BITS-1:0] bz;
	logic signed [COORD_BITS-1:0] cx;
	logic signed [COORD_BITS-1:0] cy;
	logic signed [COORD_BITS-1:0] cz;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	logic signed [COORD_BITS-1:0] point_z;

	modport source(output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
		point_x, point_y, point_z, input ready);
	modport sink(input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
		point_x, point_y, point_z, output ready);
endinterface

### hdl/pit_out_if.sv
// Result channel: one inside flag per transaction, valid/ready handshake.
// No dependencies.

interface pit_out_if;
	logic valid;
	logic ready;
	logic inside_res;

	modport source(output valid, inside_res, input ready);
	modport sink(input valid, inside_res, output ready);
endinterface

### hdl/pit_mul.sv
// Two-stage unsigned multiplier split into four half-width partial products.
// No dependencies; instantiated by point_in_triangle_test.

module pit_mul #(
	parameter int AW = 64,
	parameter int BW = 64
) (
	input  logic            clk,
	input  logic            en,
	input  logic [AW-1:0]   a,
	input  logic [BW-1:0]   b,
	output logic [AW+BW-1:0] p
);
	localparam int AL = AW / 2;
	localparam int AH = AW - AL;
	localparam int BL = BW / 2;
	localparam int BH = BW - BL;
	localparam int PW = AW + BW;

	logic [AL+BL-1:0] ll_s1;
	logic [AL+BH-1:0] lh_s1;
	logic [AH+BL-1:0] hl_s1;
	logic [AH+BH-1:0] hh_s1;
	logic [PW-1:0]    p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= a[AL-1:0] * b[BL-1:0];
			lh_s1 <= a[AL-1:0] * b[BW-1:BL];
			hl_s1 <= a[AW-1:AL] * b[BL-1:0];
			hh_s1 <= a[AW-1:AL] * b[BW-1:BL];
			p_s2  <= (PW'(hh_s1) << (AL + BL)) + (PW'(lh_s1) << BL)
				+ (PW'(hl_s1) << AL) + PW'(ll_s1);
		end
	end

	assign p = p_s2;
endmodule

### hdl/point_in_triangle_test.sv
// Point-in-triangle test, top level: pipeline, configuration registers.
// Depends on pit_pkg, pit_in_if, pit_out_if and pit_mul.
//
// One query enters per clock unless the output is stalled; the
// full-precision edge-function, normal and squared-margin products are spread
// over eleven register stages, with the widest squares done by split
// multipliers over two stages. A result that is not taken holds the whole
// pipeline, so the query side is ready whenever the output register is empty
// or being read. Clockwise triangles (in xy) have vertices b and c swapped;
// each edge rejects when its edge function is negative and its square exceeds
// four times tolerance squared times the squared xy edge length. With
// space_dim = 3 the yz plane is used when the normal's z part is the smaller
// one. Configuration must only be written while no query is in flight.

module point_in_triangle_test #(
	parameter int COORD_BITS = pit_pkg::COORD_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [pit_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [pit_pkg::CFG_DATA_W-1:0]         cfg_wdata,
	pit_in_if.sink                                 query,
	pit_out_if.source                              result
);
	localparam int N    = COORD_BITS;
	localparam int DW   = N + 1;          // coordinate difference
	localparam int PW   = 2 * N + 2;      // product of two differences
	localparam int SW   = 2 * N + 3;      // difference of two products
	localparam int MW   = 2 * N + 2;      // magnitude of SW values, edge length
	localparam int QW   = 2 * MW;         // square of a magnitude
	localparam int TSQW = 2 * pit_pkg::TOL_W;
	localparam int RPW  = TSQW + MW;
	localparam int CW   = (QW > RPW + 2) ? QW : RPW + 2;
	localparam int NSW  = QW + 1;

	// Configuration registers.
	logic [pit_pkg::DIM_W-1:0] dim_q;
	logic [pit_pkg::TOL_W-1:0] tol_q;
	logic [TSQW-1:0]           tol_sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q    <= pit_pkg::DIM_2D;
			tol_q    <= '0;
			tol_sq_q <= '0;
		end else begin
			tol_sq_q <= TSQW'(tol_q) * TSQW'(tol_q);
			if (cfg_we) begin
				unique case (cfg_index)
					pit_pkg::REG_SPACE_DIM: dim_q <= cfg_wdata[pit_pkg::DIM_W-1:0];
					pit_pkg::REG_TOLERANCE: tol_q <= cfg_wdata[pit_pkg::TOL_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Pipeline control: everything advances unless the output is stalled.
	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic vld_s7, vld_s8, vld_s9, vld_s10, vld_s11;

	assign en          = !vld_s11 || result.ready;
	assign query.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else if (en) begin
			vld_s1  <= query.valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
		end
	end

	// Stage payloads.
	logic signed [N-1:0]  v_s1 [3][3];
	logic signed [N-1:0]  p_s1 [3];
	logic signed [N-1:0]  v_s2 [3][3];
	logic signed [N-1:0]  p_s2 [3];
	logic signed [DW-1:0] e1x_s2, e1y_s2, e2x_s2, e2y_s2;
	logic signed [N-1:0]  v_s3 [3][3];
	logic signed [N-1:0]  p_s3 [3];
	logic signed [PW-1:0] cra_s3, crb_s3;
	logic signed [N-1:0]  w_c [3][3];
	logic signed [DW-1:0] ed_s4 [3][2];
	logic signed [DW-1:0] e1_s4 [3];
	logic signed [DW-1:0] e2_s4 [3];
	logic signed [DW-1:0] q_s4 [3][3];
	logic signed [PW-1:0] sq_s5 [3][2];
	logic signed [PW-1:0] np_s5 [3][2];
	logic signed [PW-1:0] dxy_s5 [3][2];
	logic signed [PW-1:0] dyz_s5 [3][2];
	logic [MW-1:0]        len_s6 [3];
	logic signed [SW-1:0] n_s6 [3];
	logic signed [SW-1:0] dxy_s6 [3];
	logic signed [SW-1:0] dyz_s6 [3];
	logic [MW-1:0]        len_s7 [3];
	logic [MW-1:0]        nm_s7 [3];
	logic [MW-1:0]        mxy_s7 [3];
	logic [MW-1:0]        myz_s7 [3];
	logic [2:0]           negxy_s7, negyz_s7, negxy_s8, negyz_s8, negxy_s9, negyz_s9;
	logic [QW-1:0]        qxy [3];
	logic [QW-1:0]        qyz [3];
	logic [QW-1:0]        nsq [3];
	logic [RPW-1:0]       rhs [3];
	logic [2:0]           rejxy_s10, rejyz_s10;
	logic [NSW-1:0]       side_s10;
	logic [QW-1:0]        n2sq_s10;
	logic                 swap_c;
	logic                 plane_yz_c;
	logic                 inside_s11;

	// Swap b and c when the xy cross product is negative.
	assign swap_c = cra_s3 < crb_s3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			w_c[0][i] = v_s3[0][i];
			w_c[1][i] = swap_c ? v_s3[2][i] : v_s3[1][i];
			w_c[2][i] = swap_c ? v_s3[1][i] : v_s3[2][i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Stage 1: input capture.
			v_s1[0][0] <= query.ax;
			v_s1[0][1] <= query.ay;
			v_s1[0][2] <= query.az;
			v_s1[1][0] <= query.bx;
			v_s1[1][1] <= query.by_coord;
			v_s1[1][2] <= query.bz;
			v_s1[2][0] <= query.cx;
			v_s1[2][1] <= query.cy;
			v_s1[2][2] <= query.cz;
			p_s1[0]    <= query.point_x;
			p_s1[1]    <= query.point_y;
			p_s1[2]    <= query.point_z;

			// Stage 2: edge vectors for the orientation test.
			v_s2   <= v_s1;
			p_s2   <= p_s1;
			e1x_s2 <= {v_s1[1][0][N-1], v_s1[1][0]} - {v_s1[0][0][N-1], v_s1[0][0]};
			e1y_s2 <= {v_s1[1][1][N-1], v_s1[1][1]} - {v_s1[0][1][N-1], v_s1[0][1]};
			e2x_s2 <= {v_s1[2][0][N-1], v_s1[2][0]} - {v_s1[0][0][N-1], v_s1[0][0]};
			e2y_s2 <= {v_s1[2][1][N-1], v_s1[2][1]} - {v_s1[0][1][N-1], v_s1[0][1]};

			// Stage 3: orientation products.
			v_s3   <= v_s2;
			p_s3   <= p_s2;
			cra_s3 <= e1x_s2 * e2y_s2;
			crb_s3 <= e1y_s2 * e2x_s2;

			// Stage 4: differences of the reordered triangle.
			for (int k = 0; k < 3; k++) begin
				for (int i = 0; i < 2; i++) begin
					ed_s4[k][i] <= {w_c[(k == 2) ? 0 : k + 1][i][N-1],
						w_c[(k == 2) ? 0 : k + 1][i]} - {w_c[k][i][N-1], w_c[k][i]};
				end
				for (int i = 0; i < 3; i++) begin
					q_s4[k][i] <= {w_c[k][i][N-1], w_c[k][i]} - {p_s3[i][N-1], p_s3[i]};
				end
				e1_s4[k] <= {w_c[1][k][N-1], w_c[1][k]} - {w_c[0][k][N-1], w_c[0][k]};
				e2_s4[k] <= {w_c[2][k][N-1], w_c[2][k]} - {w_c[0][k][N-1], w_c[0][k]};
			end

			// Stage 5: all first-level products.
			for (int k = 0; k < 3; k++) begin
				sq_s5[k][0]  <= ed_s4[k][0] * ed_s4[k][0];
				sq_s5[k][1]  <= ed_s4[k][1] * ed_s4[k][1];
				dxy_s5[k][0] <= q_s4[k][0] * q_s4[(k == 2) ? 0 : k + 1][1];
				dxy_s5[k][1] <= q_s4[k][1] * q_s4[(k == 2) ? 0 : k + 1][0];
				dyz_s5[k][0] <= q_s4[k][1] * q_s4[(k == 2) ? 0 : k + 1][2];
				dyz_s5[k][1] <= q_s4[k][2] * q_s4[(k == 2) ? 0 : k + 1][1];
			end
			np_s5[0][0] <= e1_s4[1] * e2_s4[2];
			np_s5[0][1] <= e1_s4[2] * e2_s4[1];
			np_s5[1][0] <= e1_s4[2] * e2_s4[0];
			np_s5[1][1] <= e1_s4[0] * e2_s4[2];
			np_s5[2][0] <= e1_s4[0] * e2_s4[1];
			np_s5[2][1] <= e1_s4[1] * e2_s4[0];

			// Stage 6: edge functions, normal, squared edge lengths.
			for (int k = 0; k < 3; k++) begin
				len_s6[k] <= MW'(sq_s5[k][0][PW-2:0]) + MW'(sq_s5[k][1][PW-2:0]);
				dxy_s6[k] <= {dxy_s5[k][0][PW-1], dxy_s5[k][0]}
					- {dxy_s5[k][1][PW-1], dxy_s5[k][1]};
				dyz_s6[k] <= {dyz_s5[k][0][PW-1], dyz_s5[k][0]}
					- {dyz_s5[k][1][PW-1], dyz_s5[k][1]};
				n_s6[k]   <= {np_s5[k][0][PW-1], np_s5[k][0]}
					- {np_s5[k][1][PW-1], np_s5[k][1]};
			end

			// Stage 7: magnitudes and signs.
			for (int k = 0; k < 3; k++) begin
				len_s7[k]   <= len_s6[k];
				negxy_s7[k] <= dxy_s6[k][SW-1];
				negyz_s7[k] <= dyz_s6[k][SW-1];
				mxy_s7[k]   <= dxy_s6[k][SW-1] ? MW'(-dxy_s6[k]) : MW'(dxy_s6[k]);
				myz_s7[k]   <= dyz_s6[k][SW-1] ? MW'(-dyz_s6[k]) : MW'(dyz_s6[k]);
				nm_s7[k]    <= n_s6[k][SW-1] ? MW'(-n_s6[k]) : MW'(n_s6[k]);
			end

			// Stages 8 and 9 run inside the split multipliers.
			negxy_s8 <= negxy_s7;
			negyz_s8 <= negyz_s7;
			negxy_s9 <= negxy_s8;
			negyz_s9 <= negyz_s8;

			// Stage 10: margin compares and the plane-choice sum.
			for (int k = 0; k < 3; k++) begin
				rejxy_s10[k] <= negxy_s9[k] && (CW'({rhs[k], 2'b00}) < CW'(qxy[k]));
				rejyz_s10[k] <= negyz_s9[k] && (CW'({rhs[k], 2'b00}) < CW'(qyz[k]));
			end
			side_s10 <= NSW'(nsq[0]) + NSW'(nsq[1]);
			n2sq_s10 <= nsq[2];

			// Stage 11: output register.
			inside_s11 <= plane_yz_c ? !(|rejyz_s10) : !(|rejxy_s10);
		end
	end

	assign plane_yz_c = (dim_q == pit_pkg::DIM_3D) && (NSW'(n2sq_s10) < side_s10);

	for (genvar k = 0; k < 3; k++) begin : g_sq
		pit_mul #(.AW(MW), .BW(MW)) u_qxy (
			.clk(clk), .en(en), .a(mxy_s7[k]), .b(mxy_s7[k]), .p(qxy[k])
		);
		pit_mul #(.AW(MW), .BW(MW)) u_qyz (
			.clk(clk), .en(en), .a(myz_s7[k]), .b(myz_s7[k]), .p(qyz[k])
		);
		pit_mul #(.AW(MW), .BW(MW)) u_nsq (
			.clk(clk), .en(en), .a(nm_s7[k]), .b(nm_s7[k]), .p(nsq[k])
		);
		pit_mul #(.AW(TSQW), .BW(MW)) u_rhs (
			.clk(clk), .en(en), .a(tol_sq_q), .b(len_s7[k]), .p(rhs[k])
		);
	end

	assign result.valid      = vld_s11;
	assign result.inside_res = inside_s11;

	// The pipeline must freeze completely while the output is stalled.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s1) && $stable(vld_s6) && $stable(vld_s11))
		else $error("pipeline moved during a stall");

	// The cached tolerance square tracks the tolerance register.
	a_tol_sq: assert property (@(posedge clk) disable iff (!arst_n)
		$stable(tol_q) |-> tol_sq_q == TSQW'(tol_q) * TSQW'(tol_q))
		else $error("tolerance square out of date");

	// Queries are refused only while a finished result waits to be taken.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!query.ready |-> result.valid && !result.ready)
		else $error("query side blocked without an output stall");
endmodule

### tb/point_in_triangle_test_tb.sv
// Self-checking testbench for the point-in-triangle edge-function test block.
// Depends on pit_pkg, pit_in_if, pit_out_if and the point_in_triangle_test RTL.
// Queries are driven from a queue; inside flags are predicted and compared in order.

module point_in_triangle_test_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = pit_pkg::COORD_BITS_DEF;
	localparam int WW = 256;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef logic signed [CB-1:0] coord_t;
	typedef struct packed {
		coord_t ax, ay, az, bx, by_coord, bz, cx, cy, cz, point_x, point_y, point_z;
	} query_t;
	typedef logic signed [WW-1:0] wide_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [pit_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [pit_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

	pit_in_if #(.COORD_BITS(CB)) query ();
	pit_out_if result ();

	point_in_triangle_test #(.COORD_BITS(CB)) dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .query(query.sink), .result(result.source)
	);

	always #4 clk = ~clk;

	// Predictor's copy of the configuration.
	logic [pit_pkg::DIM_W-1:0] model_dim = pit_pkg::DIM_2D;
	logic [pit_pkg::TOL_W-1:0] model_tol = '0;

	query_t pending_queries[$];
	logic expected_inside[$];
	logic exp_bit;
	int mismatches = 0;
	int accepted = 0;
	int results_seen = 0;
	int idle_cycles = 0;
	int hold_off = 0;
	bit calm = 0;
	bit sender_pause = 0;
	bit done_driving = 0;
	bit in_fire = 0;

	function automatic wide_t ext(coord_t v);
		return wide_t'(v);
	endfunction

	function automatic wide_t orient(coord_t vau, coord_t vaw, coord_t vbu, coord_t vbw,
			coord_t pu, coord_t pw);
		return (ext(vau) - ext(pu)) * (ext(vbw) - ext(pw))
			- (ext(vaw) - ext(pw)) * (ext(vbu) - ext(pu));
	endfunction

	function automatic wide_t len_sq(coord_t x0, coord_t y0, coord_t x1, coord_t y1);
		wide_t dx, dy;
		dx = ext(x1) - ext(x0);
		dy = ext(y1) - ext(y0);
		return dx * dx + dy * dy;
	endfunction

	function automatic bit edge_rejects(wide_t d, wide_t l2);
		wide_t t;
		t = wide_t'({1'b0, model_tol});
		if (d >= 0)
			return 0;
		return (t * t * l2 * 4) < (d * d);
	endfunction

	function automatic bit predict_inside(query_t q);
		coord_t vx[3], vy[3], vz[3], tmp;
		wide_t l[3], e1x, e1y, e1z, e2x, e2y, e2z, n0, n1, n2, d;
		bit use_yz;
		int k, k2;
		vx = '{q.ax, q.bx, q.cx};
		vy = '{q.ay, q.by_coord, q.cy};
		vz = '{q.az, q.bz, q.cz};
		if (orient(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2]) < 0) begin
			tmp = vx[1]; vx[1] = vx[2]; vx[2] = tmp;
			tmp = vy[1]; vy[1] = vy[2]; vy[2] = tmp;
			tmp = vz[1]; vz[1] = vz[2]; vz[2] = tmp;
		end
		for (k = 0; k < 3; k++)
			l[k] = len_sq(vx[k], vy[k], vx[(k + 1) % 3], vy[(k + 1) % 3]);
		use_yz = 0;
		if (model_dim == pit_pkg::DIM_3D) begin
			e1x = ext(vx[1]) - ext(vx[0]); e1y = ext(vy[1]) - ext(vy[0]);
			e1z = ext(vz[1]) - ext(vz[0]); e2x = ext(vx[2]) - ext(vx[0]);
			e2y = ext(vy[2]) - ext(vy[0]); e2z = ext(vz[2]) - ext(vz[0]);
			n0 = e1y * e2z - e1z * e2y;
			n1 = e1z * e2x - e1x * e2z;
			n2 = e1x * e2y - e1y * e2x;
			use_yz = (n2 * n2) < (n0 * n0 + n1 * n1);
		end
		for (k = 0; k < 3; k++) begin
			k2 = (k + 1) % 3;
			if (use_yz)
				d = orient(vy[k], vz[k], vy[k2], vz[k2], q.point_y, q.point_z);
			else
				d = orient(vx[k], vy[k], vx[k2], vy[k2], q.point_x, q.point_y);
			if (edge_rejects(d, l[k]))
				return 0;
		end
		return 1;
	endfunction

	function automatic coord_t rand_coord(int mode);
		case (mode)
			0: return coord_t'($urandom);
			1: return coord_t'($urandom_range(0, 20) * 32'sh10000) - 32'sh000A0000;
			default: return coord_t'(int'($urandom_range(0, 8191)) - 4096) <<< 8;
		endcase
	endfunction

	function automatic query_t rand_query();
		query_t q;
		int mode;
		int w0, w1, w2, s;
		mode = $urandom_range(0, 9) < 2 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
		q.ax = rand_coord(mode); q.ay = rand_coord(mode); q.az = rand_coord(mode);
		q.bx = rand_coord(mode); q.by_coord = rand_coord(mode); q.bz = rand_coord(mode);
		q.cx = rand_coord(mode); q.cy = rand_coord(mode); q.cz = rand_coord(mode);
		if (mode != 0 && $urandom_range(0, 1)) begin
			// Barycentric point, mostly inside, sometimes slightly outside.
			w0 = $urandom_range(0, 100); w1 = $urandom_range(0, 100);
			w2 = $urandom_range(0, 100) + 1; s = w0 + w1 + w2;
			q.point_x = coord_t'((longint'(q.ax) * w0 + longint'(q.bx) * w1
				+ longint'(q.cx) * w2) / s);
			q.point_y = coord_t'((longint'(q.ay) * w0 + longint'(q.by_coord) * w1
				+ longint'(q.cy) * w2) / s);
			q.point_z = coord_t'((longint'(q.az) * w0 + longint'(q.bz) * w1
				+ longint'(q.cz) * w2) / s);
			if ($urandom_range(0, 2) == 0) begin
				q.point_x = q.point_x + coord_t'(int'($urandom_range(0, 4096)) - 2048);
				q.point_y = q.point_y + coord_t'(int'($urandom_range(0, 4096)) - 2048);
			end
		end else begin
			q.point_x = rand_coord(mode); q.point_y = rand_coord(mode);
			q.point_z = rand_coord(mode);
		end
		return q;
	endfunction

	function automatic query_t make_query(coord_t ax, coord_t ay, coord_t bx, coord_t by,
			coord_t cx, coord_t cy, coord_t px, coord_t py);
		query_t q;
		q = '0;
		q.ax = ax; q.ay = ay; q.bx = bx; q.by_coord = by; q.cx = cx; q.cy = cy;
		q.point_x = px; q.point_y = py;
		return q;
	endfunction

	// Remembers whether the offered query was taken at the last rising edge.
	always @(posedge clk) begin
		in_fire <= query.valid && query.ready;
	end

	// Driver: presents the head of the queue, new data after a transaction.
	always @(negedge clk) begin
		if (!arst_n) begin
			query.valid <= 1'b0;
		end else if (query.valid && !in_fire) begin
			// Hold the offered transaction.
		end else if (pending_queries.size() > 0 && !sender_pause
				&& (calm || $urandom_range(0, 99) >= 14)) begin
			query.valid <= 1'b1;
			{query.ax, query.ay, query.az, query.bx, query.by_coord, query.bz,
				query.cx, query.cy, query.cz, query.point_x, query.point_y,
				query.point_z} <= pending_queries.pop_front();
		end else begin
			query.valid <= 1'b0;
		end
	end

	// Result side readiness with random stalls and one long hold-off.
	always @(negedge clk) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			result.ready <= 1'b0;
		end else begin
			result.ready <= calm || $urandom_range(0, 99) >= 14;
		end
	end

	// Monitor: predicts on accepted queries, checks accepted results.
	always @(posedge clk) begin
		if (arst_n) begin
			if (query.valid && query.ready) begin
				expected_inside.push_back(predict_inside({query.ax, query.ay, query.az,
					query.bx, query.by_coord, query.bz, query.cx, query.cy, query.cz,
					query.point_x, query.point_y, query.point_z}));
				accepted++;
			end
			if (result.valid && result.ready) begin
				results_seen++;
				if (expected_inside.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: result transaction with nothing expected, inside_res=%b",
							result.inside_res);
				end else begin
					exp_bit = expected_inside.pop_front();
					if (exp_bit !== result.inside_res) begin
						mismatches++;
						if (mismatches <= 10)
							$display("ERROR: result %0d inside_res expected %b got %b",
								results_seen, exp_bit, result.inside_res);
					end
				end
			end
			if ((query.valid && query.ready) || (result.valid && result.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL point_in_triangle_test");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [pit_pkg::CFG_IDX_W-1:0] idx,
			logic [pit_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == pit_pkg::REG_SPACE_DIM)
			model_dim = data[pit_pkg::DIM_W-1:0];
		else
			model_tol = data[pit_pkg::TOL_W-1:0];
	endtask

	task automatic drain();
		wait (pending_queries.size() == 0 && !query.valid);
		wait (expected_inside.size() == 0);
		repeat (20) @(negedge clk);
	endtask

	task automatic run_phase(logic [pit_pkg::DIM_W-1:0] dim, logic [pit_pkg::TOL_W-1:0] tol,
			int n);
		int i;
		write_reg(pit_pkg::REG_SPACE_DIM, pit_pkg::CFG_DATA_W'(dim));
		write_reg(pit_pkg::REG_TOLERANCE, pit_pkg::CFG_DATA_W'(tol));
		for (i = 0; i < n; i++)
			pending_queries.push_back(rand_query());
		drain();
	endtask

	initial begin
		query_t q;
		int i;
		query.valid = 1'b0;
		{query.ax, query.ay, query.az, query.bx, query.by_coord, query.bz, query.cx,
			query.cy, query.cz, query.point_x, query.point_y, query.point_z} = '0;
		result.ready = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: orientation, edges, extremes, degenerate cases, tolerance, 3D plane choice.
		write_reg(pit_pkg::REG_SPACE_DIM, pit_pkg::CFG_DATA_W'(pit_pkg::DIM_2D));
		write_reg(pit_pkg::REG_TOLERANCE, '0);
		pending_queries.push_back(make_query(0, 0, 32'sh40000, 0, 0, 32'sh40000,
			32'sh10000, 32'sh10000));
		pending_queries.push_back(make_query(0, 0, 0, 32'sh40000, 32'sh40000, 0,
			32'sh10000, 32'sh10000));
		pending_queries.push_back(make_query(0, 0, 32'sh40000, 0, 0, 32'sh40000,
			32'sh50000, 32'sh50000));
		pending_queries.push_back(make_query(0, 0, 32'sh40000, 0, 0, 32'sh40000,
			32'sh20000, 0));
		pending_queries.push_back(make_query(0, 0, 32'sh40000, 0, 0, 32'sh40000,
			32'sh10000, -1));
		pending_queries.push_back(make_query(5, 5, 5, 5, 5, 5, 5, 5));
		pending_queries.push_back(make_query(5, 5, 5, 5, 5, 5, 6, 5));
		pending_queries.push_back(make_query(32'h80000000, 32'h80000000, 32'h7fffffff,
			32'h80000000, 32'h80000000, 32'h7fffffff, 0, 0));
		pending_queries.push_back(make_query(32'h80000000, 32'h80000000, 32'h7fffffff,
			32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
		q = '1;
		pending_queries.push_back(q);
		drain();
		write_reg(pit_pkg::REG_TOLERANCE, pit_pkg::CFG_DATA_W'(32'h10000));
		pending_queries.push_back(make_query(0, 0, 32'sh40000, 0, 0, 32'sh40000,
			32'sh10000, -32'sh8000));
		pending_queries.push_back(make_query(0, 0, 32'sh40000, 0, 0, 32'sh40000,
			32'sh10000, -32'sh30000));
		drain();
		write_reg(pit_pkg::REG_SPACE_DIM, pit_pkg::CFG_DATA_W'(pit_pkg::DIM_3D));
		write_reg(pit_pkg::REG_TOLERANCE, '0);
		q = make_query(0, 0, 0, 0, 0, 32'sh40000, 0, 32'sh10000);
		q.bz = 32'sh40000; q.point_z = 32'sh10000;
		pending_queries.push_back(q);
		q.point_z = -32'sh10000;
		pending_queries.push_back(q);
		pending_queries.push_back(make_query(3, 3, 3, 3, 3, 3, 3, 3));
		pending_queries.push_back(make_query(0, 0, 32'sh40000, 0, 0, 32'sh40000,
			32'sh10000, 32'sh10000));
		drain();

		// Random phases across register settings, extremes included.
		run_phase(2'd0, '0, 60);
		run_phase(2'd1, 31'h7fffffff, 40);
		run_phase(pit_pkg::DIM_2D, 31'd4096, 120);
		calm = 1;
		run_phase(pit_pkg::DIM_3D, '0, 80);
		calm = 0;
		run_phase(pit_pkg::DIM_3D, 31'd65536, 120);

		// Long receiver hold-off while queries keep coming.
		hold_off = 300;
		run_phase(pit_pkg::DIM_2D, 31'd256, 100);

		// Sender pauses mid-stream until all results are back, then resumes.
		write_reg(pit_pkg::REG_SPACE_DIM, pit_pkg::CFG_DATA_W'(pit_pkg::DIM_3D));
		write_reg(pit_pkg::REG_TOLERANCE, pit_pkg::CFG_DATA_W'(31'h7fffffff));
		for (i = 0; i < 80; i++)
			pending_queries.push_back(rand_query());
		wait (pending_queries.size() <= 40);
		sender_pause = 1;
		wait (expected_inside.size() == 0);
		sender_pause = 0;
		drain();
		run_phase(pit_pkg::DIM_2D, '0, 80);

		repeat (30) @(negedge clk);
		$display("Covered %0d queries in 2D and 3D with tolerances from zero to full scale,",
			accepted);
		$display("including orientation swaps, degenerate triangles and output back-pressure.");
		if (mismatches == 0 && expected_inside.size() == 0)
			$display("PASS point_in_triangle_test");
		else
			$display("FAIL point_in_triangle_test");
		$finish;
	end
endmodule

### files.f
hdl/pit_pkg.sv
hdl/pit_in_if.sv
hdl/pit_out_if.sv
hdl/pit_mul.sv
hdl/point_in_triangle_test.sv
tb/point_in_triangle_test_tb.sv
